// File: hw/rtl/npr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npr_pkg
// Shared types and constants for the nearest place resolver.
// ----------------------------------------------------------------------------
package npr_pkg;

    localparam int MODE_W    = 2;
    localparam int LAT_W     = 31;
    localparam int LON_W     = 32;
    localparam int TAG_IN_W  = 16;
    localparam int IDX_OUT_W = 8;
    localparam int SQ_LAT_W  = 2 * (LAT_W - 1) + 2;   // |dlat| < 2^31
    localparam int SQ_LON_W  = 2 * LON_W;             // |dlon| < 2^32
    localparam int DIST_W    = SQ_LON_W + 1;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    typedef struct packed {
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } t_coord;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

// File: hw/rtl/npr_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npr_dist
// Two-stage squared distance pipe: absolute differences, then squares.
// A side payload (index and tag) travels along with each entry.
// ----------------------------------------------------------------------------
module npr_dist
    import npr_pkg::*;
#(
    parameter int SIDE_W = 24
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_vld,
    input  t_coord              i_pt,
    input  t_coord              i_q,
    input  wire  [SIDE_W-1:0]   i_side,
    output logic                o_vld,
    output logic                o_busy,
    output logic [SQ_LAT_W-1:0] o_sq_lat,
    output logic [SQ_LON_W-1:0] o_sq_lon,
    output logic [SIDE_W-1:0]   o_side
);

    logic                  r_vld1;
    logic [LAT_W-1:0]      r_dlat;
    logic [LON_W-1:0]      r_dlon;
    logic [SIDE_W-1:0]     r_side1;

    logic signed [LAT_W:0] w_pa;
    logic signed [LAT_W:0] w_qa;
    logic signed [LON_W:0] w_po;
    logic signed [LON_W:0] w_qo;
    logic [LAT_W:0]        w_dlat_pq;
    logic [LAT_W:0]        w_dlat_qp;
    logic [LON_W:0]        w_dlon_pq;
    logic [LON_W:0]        w_dlon_qp;

    // one bit of headroom, both subtraction orders side by side
    assign w_pa      = (LAT_W+1)'(i_pt.lat);
    assign w_qa      = (LAT_W+1)'(i_q.lat);
    assign w_po      = (LON_W+1)'(i_pt.lon);
    assign w_qo      = (LON_W+1)'(i_q.lon);
    assign w_dlat_pq = w_pa - w_qa;
    assign w_dlat_qp = w_qa - w_pa;
    assign w_dlon_pq = w_po - w_qo;
    assign w_dlon_qp = w_qo - w_po;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            o_vld  <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dlat   <= (w_pa >= w_qa) ? w_dlat_pq[LAT_W-1:0] : w_dlat_qp[LAT_W-1:0];
        r_dlon   <= (w_po >= w_qo) ? w_dlon_pq[LON_W-1:0] : w_dlon_qp[LON_W-1:0];
        r_side1  <= i_side;
        o_sq_lat <= SQ_LAT_W'(r_dlat) * SQ_LAT_W'(r_dlat);
        o_sq_lon <= SQ_LON_W'(r_dlon) * SQ_LON_W'(r_dlon);
        o_side   <= r_side1;
    end

    assign o_busy = r_vld1 | o_vld;

endmodule
`default_nettype wire

// File: hw/rtl/nearest_place_resolver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_place_resolver
// Place table with a nearest-place query by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries mode, latitude, longitude and tag.
// Clear, accepted append and the unused mode produce no result. A refused
// append (table full) and a query each produce one result transaction on
// the output channel (o_valid/i_ready).
// A query streams every stored entry out of the place memory, one per cycle,
// through a read / difference / square / compare pipe, and the result is
// loaded once the pipe has drained. The single memory read port sets the
// streaming rate.
// The result sits in an output register; a new transaction is taken while it
// waits, but the next result is held back until the receiver takes the old
// one, and no input is taken in the meantime.
// Reset empties the table and forgets the last reported tag; the memory
// itself is not cleared, only the fill count is.
// ----------------------------------------------------------------------------
module nearest_place_resolver
    import npr_pkg::*;
#(
    parameter int MAX_PLACES = 256,
    parameter int TAG_BITS   = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [MODE_W-1:0]          i_mode,
    input  wire  signed [LAT_W-1:0]    i_latitude,
    input  wire  signed [LON_W-1:0]    i_longitude,
    input  wire  [TAG_IN_W-1:0]        i_place_tag,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic                       o_found,
    output logic [TAG_IN_W-1:0]        o_nearest_tag,
    output logic [IDX_OUT_W-1:0]       o_nearest_index,
    output logic                       o_changed,
    output logic                       o_table_full
);

    localparam int TW     = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
    localparam int IDX_W  = (MAX_PLACES > 1) ? $clog2(MAX_PLACES) : 1;
    localparam int CNT_W  = $clog2(MAX_PLACES + 1);
    localparam int ENT_W  = LAT_W + LON_W + TW;
    localparam int SIDE_W = IDX_W + TW;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [TW-1:0]       r_last_tag;
    logic                r_last_valid;
    t_coord              r_q;
    logic [CNT_W-1:0]    r_rd_ptr;
    logic                r_v1;
    logic [IDX_W-1:0]    r_idx1;
    logic [ENT_W-1:0]    r_rd_data;
    logic                r_have;
    logic [DIST_W-1:0]   r_best_dist;
    logic [IDX_W-1:0]    r_best_idx;
    logic [TW-1:0]       r_best_tag;
    logic                r_p_full;

    logic [ENT_W-1:0]    mem_places [MAX_PLACES];

    logic                w_accept;
    logic                w_full;
    logic                w_wr_en;
    logic                w_issue;
    logic                w_scan_done;
    logic                w_emit;
    logic                w_chg;
    logic                w_better;
    logic [DIST_W-1:0]   w_dist;
    t_coord              w_pt;
    logic [TW-1:0]       w_rd_tag;

    logic                d_vld;
    logic                d_busy;
    logic [SQ_LAT_W-1:0] d_sq_lat;
    logic [SQ_LON_W-1:0] d_sq_lon;
    logic [SIDE_W-1:0]   d_side;

    assign w_accept = i_valid & o_ready;
    assign w_full   = (r_cnt == CNT_W'(MAX_PLACES));
    assign w_wr_en  = w_accept & (i_mode == MODE_APPEND) & ~w_full;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        MODE_APPEND: if (w_full) n_state = ST_EMIT;
                        MODE_QUERY:  n_state = (r_cnt == '0) ? ST_EMIT : ST_SCAN;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: if (w_scan_done) n_state = ST_EMIT;
            ST_EMIT: if (w_emit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready     = (r_state == ST_IDLE);
        w_issue     = (r_state == ST_SCAN) && (r_rd_ptr != r_cnt);
        w_scan_done = (r_state == ST_SCAN) && !w_issue && !r_v1 && !d_busy;
        w_emit      = (r_state == ST_EMIT) && (!o_valid || i_ready);
    end

    // place memory, one write and one read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_places[r_cnt[IDX_W-1:0]] <= {i_latitude, i_longitude, i_place_tag[TW-1:0]};
        end
        if (w_issue) begin
            r_rd_data <= mem_places[r_rd_ptr[IDX_W-1:0]];
        end
        r_idx1 <= r_rd_ptr[IDX_W-1:0];
    end

    assign w_pt.lat = r_rd_data[ENT_W-1 -: LAT_W];
    assign w_pt.lon = r_rd_data[TW +: LON_W];
    assign w_rd_tag = r_rd_data[TW-1:0];

    npr_dist #(
        .SIDE_W (SIDE_W)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_v1),
        .i_pt     (w_pt),
        .i_q      (r_q),
        .i_side   ({r_idx1, w_rd_tag}),
        .o_vld    (d_vld),
        .o_busy   (d_busy),
        .o_sq_lat (d_sq_lat),
        .o_sq_lon (d_sq_lon),
        .o_side   (d_side)
    );

    assign w_dist   = DIST_W'(d_sq_lat) + DIST_W'(d_sq_lon);
    // strict less keeps the first entry on a tie
    assign w_better = !r_have || (w_dist < r_best_dist);
    assign w_chg    = r_have && (!r_last_valid || (r_last_tag != r_best_tag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_last_tag   <= '0;
            r_last_valid <= 1'b0;
            r_rd_ptr     <= '0;
            r_v1         <= 1'b0;
            r_have       <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            if (w_issue) begin
                r_rd_ptr <= r_rd_ptr + CNT_W'(1);
            end
            if (d_vld && w_better) begin
                r_have <= 1'b1;
            end
            if (w_accept) begin
                r_rd_ptr <= '0;
                r_have   <= 1'b0;
                case (i_mode)
                    MODE_CLEAR: begin
                        r_cnt        <= '0;
                        r_last_tag   <= '0;
                        r_last_valid <= 1'b0;
                    end
                    MODE_APPEND: if (!w_full) r_cnt <= r_cnt + CNT_W'(1);
                    default: ;
                endcase
            end
            if (w_emit) begin
                o_valid <= 1'b1;
                if (w_chg) begin
                    r_last_tag   <= r_best_tag;
                    r_last_valid <= 1'b1;
                end
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q.lat  <= i_latitude;
            r_q.lon  <= i_longitude;
            r_p_full <= w_full;
        end
        if (d_vld && w_better) begin
            r_best_dist <= w_dist;
            r_best_idx  <= d_side[SIDE_W-1 -: IDX_W];
            r_best_tag  <= d_side[TW-1:0];
        end
        if (w_emit) begin
            o_found         <= r_have;
            o_nearest_tag   <= r_have ? TAG_IN_W'(r_best_tag) : '0;
            o_nearest_index <= r_have ? IDX_OUT_W'(r_best_idx) : '0;
            o_changed       <= w_chg;
            o_table_full    <= r_p_full;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_PLACES))
        else $error("entry count beyond capacity");

    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || d_busy) |-> (r_state == ST_SCAN))
        else $error("distance pipe active outside a scan");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_nearest_tag == '0 && !o_changed))
        else $error("result without a place carries tag or change");

    a_last_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_chg) |=> (r_last_valid && o_changed && r_last_tag == $past(r_best_tag)))
        else $error("reported tag not recorded");

    a_no_input_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> $stable(r_cnt))
        else $error("table changed during a scan");

endmodule
`default_nettype wire
